### rtl/kpd_pkg.sv
// ---------------------------------------------------------------------------
// kpd_pkg
// types and constants shared by the keystroke program decoder
// ---------------------------------------------------------------------------
`default_nettype none

package kpd_pkg;

  localparam int unsigned ByteW = 8;

  localparam logic [ByteW-1:0] EscapeByte   = 8'h00;
  localparam logic [ByteW-1:0] UsageMask    = 8'h7F;
  localparam logic [ByteW-1:0] ShiftBit     = 8'h80;
  localparam logic [ByteW-1:0] LeftShiftMod = 8'h02;
  localparam logic [ByteW-1:0] NoKey        = 8'h00;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_MODIFIER = 2'd1,
    PH_USAGE    = 2'd2
  } phase_e;

  typedef enum logic {
    BK_PRESS   = 1'b0,
    BK_RELEASE = 1'b1
  } back_e;

  typedef struct packed {
    logic [ByteW-1:0] usage;
    logic [ByteW-1:0] modifier;
  } keystroke_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage : kpd_pkg

`default_nettype wire

### rtl/kpd_front.sv
// ---------------------------------------------------------------------------
// kpd_front
// takes program bytes, tracks escapes and queues whole keystrokes
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_front
  import kpd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output      logic          in_ready_o,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          in_final_i,
  input  wire queue_status_t q_status_i,
  output      logic          push_o,
  output      keystroke_t    push_key_o
);

  phase_e           phase_q, phase_d;
  logic [ByteW-1:0] held_mod_q, held_mod_d;
  logic             accept;
  logic             key_done;

  assign in_ready_o = !q_status_i.full;
  assign accept     = in_valid_i && in_ready_o;

  always_comb begin
    phase_d    = phase_q;
    held_mod_d = held_mod_q;
    key_done   = 1'b0;
    push_key_o = '{usage: NoKey, modifier: NoKey};
    if (accept) begin
      unique case (phase_q)
        PH_MODIFIER: begin
          held_mod_d = in_byte_i;
          phase_d    = PH_USAGE;
        end
        PH_USAGE: begin
          key_done   = 1'b1;
          push_key_o = '{usage: in_byte_i, modifier: held_mod_q};
          phase_d    = PH_IDLE;
        end
        default: begin
          if (in_byte_i == EscapeByte) begin
            phase_d = PH_MODIFIER;
          end else begin
            key_done   = 1'b1;
            push_key_o = '{usage:    in_byte_i & UsageMask,
                           modifier: ((in_byte_i & ShiftBit) != NoKey) ? LeftShiftMod
                                                                      : NoKey};
            phase_d    = PH_IDLE;
          end
        end
      endcase
      if (in_final_i) begin
        phase_d = PH_IDLE;
      end
    end
  end

  // zero usage keystrokes produce no reports
  assign push_o = key_done && (push_key_o.usage != NoKey);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      held_mod_q <= NoKey;
    end else begin
      phase_q    <= phase_d;
      held_mod_q <= held_mod_d;
    end
  end

endmodule : kpd_front

`default_nettype wire

### rtl/kpd_queue.sv
// ---------------------------------------------------------------------------
// kpd_queue
// two-entry keystroke queue between the front and back parts
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_queue
  import kpd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          push_i,
  input  wire keystroke_t    push_key_i,
  input  wire logic          pop_i,
  output      keystroke_t    head_o,
  output      queue_status_t status_o
);

  localparam int unsigned Depth = 2;

  keystroke_t entry_q [Depth];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push;
  logic       do_pop;

  assign status_o.full  = (count_q == 2'(Depth));
  assign status_o.empty = (count_q == 2'd0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop  ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (do_push && !do_pop) begin
      count_d = count_q + 2'd1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entry_q[wr_ptr_q] <= push_key_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

endmodule : kpd_queue

`default_nettype wire

### rtl/kpd_back.sv
// ---------------------------------------------------------------------------
// kpd_back
// turns each queued keystroke into a press and a release report
// ---------------------------------------------------------------------------
`default_nettype none

module kpd_back
  import kpd_pkg::*;
(
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire keystroke_t    head_i,
  input  wire queue_status_t q_status_i,
  output      logic          pop_o,
  output      logic          out_valid_o,
  input  wire logic          out_ready_i,
  output      keystroke_t    out_key_o,
  output      logic          out_last_o
);

  back_e      state_q, state_d;
  logic       out_valid_q, out_valid_d;
  keystroke_t out_key_q, out_key_d;
  logic       out_last_q, out_last_d;
  logic       load;

  assign load = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    if (load) begin
      unique case (state_q)
        BK_PRESS: begin
          if (!q_status_i.empty) begin
            state_d = BK_RELEASE;
          end
        end
        BK_RELEASE: state_d = BK_PRESS;
        default:    state_d = BK_PRESS;
      endcase
    end
  end

  // output register and queue pop
  always_comb begin
    pop_o       = 1'b0;
    out_valid_d = out_valid_q;
    out_key_d   = out_key_q;
    out_last_d  = out_last_q;
    if (load) begin
      unique case (state_q)
        BK_PRESS: begin
          pop_o       = !q_status_i.empty;
          out_valid_d = !q_status_i.empty;
          out_key_d   = head_i;
          out_last_d  = 1'b0;
        end
        default: begin
          out_valid_d = 1'b1;
          out_key_d   = '{usage: NoKey, modifier: NoKey};
          out_last_d  = 1'b1;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_key_o   = out_key_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i) begin
    out_key_q  <= out_key_d;
    out_last_q <= out_last_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_PRESS;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule : kpd_back

`default_nettype wire

### rtl/keystroke_program_decoder.sv
// ---------------------------------------------------------------------------
// keystroke_program_decoder
// decodes a stored keystroke program into keyboard press/release reports
//
// input stream: one program byte per transaction in s_axis_tdata, s_axis_tlast
// marks the final byte of the program. a plain byte is a keystroke, a zero
// byte starts an escape whose next two bytes are modifier and usage.
// output stream: one report per transaction, modifier in bits 7:0 and usage
// in bits 15:8 of m_axis_tdata; m_axis_tlast flags the all-zero release that
// follows each press. keystrokes with a zero usage give no reports.
// the front part takes a byte every cycle while the two-entry keystroke
// queue has room; the back part sends one report per cycle from an output
// register while the receiver takes them, a press and then a release for
// each keystroke, which is queued before it reaches the output register.
// when the receiver stalls, the report holds, the queue fills and then
// s_axis_tready drops until a keystroke moves to the back part.
// reset clears the escape tracking, the queue and the output valid flag.
// ---------------------------------------------------------------------------
`default_nettype none

module keystroke_program_decoder
  import kpd_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] program_byte
  input  wire logic        s_axis_tlast,   // final_byte
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [15:0] m_axis_tdata,   // [7:0] modifier, [15:8] usage
  output      logic        m_axis_tlast    // end_of_run
);

  queue_status_t q_status;
  logic          push;
  keystroke_t    push_key;
  logic          pop;
  keystroke_t    head_key;
  keystroke_t    out_key;

  kpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_byte_i  (s_axis_tdata),
    .in_final_i (s_axis_tlast),
    .q_status_i (q_status),
    .push_o     (push),
    .push_key_o (push_key)
  );

  kpd_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .push_key_i (push_key),
    .pop_i      (pop),
    .head_o     (head_key),
    .status_o   (q_status)
  );

  kpd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head_key),
    .q_status_i  (q_status),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_key_o   (out_key),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {out_key.usage, out_key.modifier};

endmodule : keystroke_program_decoder

`default_nettype wire

### tb/keystroke_program_decoder_tb.sv
// ---------------------------------------------------------------------------
// keystroke_program_decoder_tb
// self-checking testbench for the keystroke program decoder
//
// program bytes go in on the slave stream and the reports that come out on
// the master stream are compared with a predicted queue of reports. the run
// starts with directed keystrokes: plain and shifted bytes, escapes, zero
// usages and escapes cut short by the final byte. it then sends random
// programs of well-formed keystrokes with some noise and broken escapes.
// both streams idle at random between transactions, with stretches of no
// idling at all.
// ---------------------------------------------------------------------------
`default_nettype none

module keystroke_program_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import kpd_pkg::*;

  localparam int RandomBytes = 1800;
  localparam int CycleLimit  = 300000;
  localparam int DrainCycles = 20;
  localparam int ShownErrors = 10;

  typedef struct packed {
    logic [7:0] modifier;
    logic [7:0] usage;
    logic       end_of_run;
  } report_t;

  class report_scoreboard;
    phase_e     phase;
    logic [7:0] held_mod;
    report_t    report_q[$];
    int         mismatches;
    int         checked;

    function new();
      phase      = PH_IDLE;
      held_mod   = NoKey;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void push_keystroke(logic [7:0] modifier, logic [7:0] usage);
      if (usage == NoKey) return;
      report_q.push_back('{modifier: modifier, usage: usage, end_of_run: BK_PRESS});
      report_q.push_back('{modifier: NoKey, usage: NoKey, end_of_run: BK_RELEASE});
    endfunction

    function void note_byte(logic [7:0] prog_byte, logic final_flag);
      case (phase)
        PH_MODIFIER: begin
          held_mod = prog_byte;
          phase    = PH_USAGE;
        end
        PH_USAGE: begin
          push_keystroke(held_mod, prog_byte);
          phase = PH_IDLE;
        end
        default: begin
          if (prog_byte == EscapeByte) begin
            phase = PH_MODIFIER;
          end else begin
            push_keystroke(((prog_byte & ShiftBit) != 0) ? LeftShiftMod : NoKey,
                           prog_byte & UsageMask);
            phase = PH_IDLE;
          end
        end
      endcase
      if (final_flag) phase = PH_IDLE;
    endfunction

    function void check_report(report_t got);
      report_t want;
      checked++;
      if (report_q.size() == 0) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("unexpected report: mod %h usage %h last %b",
                   got.modifier, got.usage, got.end_of_run);
        return;
      end
      want = report_q.pop_front();
      if (got.modifier !== want.modifier || got.usage !== want.usage ||
          got.end_of_run !== want.end_of_run) begin
        mismatches++;
        if (mismatches <= ShownErrors)
          $display("report %0d: expected mod %h usage %h last %b, got mod %h usage %h last %b",
                   checked, want.modifier, want.usage, want.end_of_run,
                   got.modifier, got.usage, got.end_of_run);
      end
    endfunction

    function int pending();
      return report_q.size();
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] program_byte
  logic        s_axis_tlast = 1'b0;    // final_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;           // [7:0] modifier, [15:8] usage
  logic        m_axis_tlast;           // end_of_run

  report_scoreboard sb = new();
  logic quiet = 1'b0;
  int   bytes_sent = 0;
  int   programs_sent = 0;
  int   cycles = 0;

  keystroke_program_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] prog_byte, input logic final_flag);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= prog_byte;
    s_axis_tlast  <= final_flag;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_byte(prog_byte, final_flag);
    bytes_sent++;
  endtask

  task automatic send_random_program();
    logic [7:0] prog_q[$];
    int         n_keys;
    int         kind;
    n_keys = $urandom_range(1, 6);
    for (int k = 0; k < n_keys; k++) begin
      kind = $urandom_range(0, 19);
      if (kind < 13) begin
        prog_q.push_back(8'($urandom_range(1, 255)));
      end else if (kind < 18) begin
        prog_q.push_back(EscapeByte);
        prog_q.push_back(8'($urandom_range(0, 255)));
        prog_q.push_back(($urandom_range(0, 7) == 0) ? NoKey : 8'($urandom_range(1, 255)));
      end else begin
        prog_q.push_back(8'($urandom_range(0, 255)));
      end
    end
    // escape cut short by the final byte
    if ($urandom_range(0, 7) == 0) begin
      prog_q.push_back(EscapeByte);
      if ($urandom_range(0, 1) == 1) prog_q.push_back(8'($urandom_range(0, 255)));
    end
    foreach (prog_q[i]) send_byte(prog_q[i], i == prog_q.size() - 1);
    programs_sent++;
  endtask

  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = quiet ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      sb.check_report('{modifier: m_axis_tdata[7:0], usage: m_axis_tdata[15:8],
                        end_of_run: m_axis_tlast});
    end
  end

  initial begin
    // bit 8 is the final-byte flag
    logic [8:0] directed [25] = '{
      9'h001, 9'h07F, 9'h080, 9'h0FF, 9'h081,
      9'h000, 9'h0A5, 9'h004,
      9'h000, 9'h012, 9'h000,
      9'h000, 9'h0FF, 9'h0FF,
      9'h000, 9'h000, 9'h03C,
      9'h100, 9'h005,
      9'h000, 9'h133, 9'h106,
      9'h000, 9'h011, 9'h122
    };
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i][7:0], directed[i][8]);

    while (bytes_sent < RandomBytes + $size(directed)) begin
      if (programs_sent % 20 == 0) quiet = ($urandom_range(0, 3) == 0);
      send_random_program();
    end
    s_axis_tvalid <= 1'b0;
    quiet = 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("sent %0d program bytes in %0d programs, checked %0d reports",
             bytes_sent, programs_sent + 1, sb.checked);
    $display("mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
rtl/kpd_pkg.sv
rtl/kpd_front.sv
rtl/kpd_queue.sv
rtl/kpd_back.sv
rtl/keystroke_program_decoder.sv
tb/keystroke_program_decoder_tb.sv
